// ===== rtl/psba_pkg.sv =====
// Shared types and constants for the page slot bitmap allocator.
// No dependencies; every other file in the block imports this package.
package psba_pkg;

  // Field widths fixed by the item and register formats.
  localparam int unsigned SLOT_W  = 9;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned CAP_W   = 10;

  // Bitmap memory word geometry.
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WORD_LW = 5;

  // APB port geometry: one register at byte address 0.
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Register index as seen in the word-address bit of paddr.
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_RECOVER = 2'd1,
    MODE_DELETE  = 2'd2,
    MODE_LOOKUP  = 2'd3
  } mode_e;

  // Status codes carried by a result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

// ===== rtl/psba_req_if.sv =====
// Request channel of the page slot bitmap allocator: valid/ready plus the item fields.
// Depends on psba_pkg for the operation code type.
interface psba_req_if import psba_pkg::*; ();

  logic              valid;
  logic              ready;
  mode_e             mode;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output mode, output slot, input ready);
  modport sink   (input valid, input mode, input slot, output ready);

endinterface

// ===== rtl/psba_rsp_if.sv =====
// Result channel of the page slot bitmap allocator: valid/ready plus the result fields.
// Depends on psba_pkg for the status code type.
interface psba_rsp_if import psba_pkg::*; ();

  logic              valid;
  logic              ready;
  status_e           status;
  logic [SLOT_W-1:0] result_slot;
  logic [CNT_W-1:0]  used_count;

  modport source (output valid, output status, output result_slot, output used_count,
                  input ready);
  modport sink   (input valid, input status, input result_slot, input used_count,
                  output ready);

endinterface

// ===== rtl/page_slot_bitmap_allocator.sv =====
// Flow: recovery insert, delete and lookup read the slot's word, update it in S_MOD and hand the result
// to the output register via S_PUT; an out-of-range slot goes straight to S_PUT; insert scans 32-bit words
// from word 0 in S_SCAN until a free slot or the last usable word. One item at a time: ready only in S_IDLE;
// the single read port of the bitmap memory delivers one word per cycle.
// Reset: count zero, capacity 512; per-word valid flags make the bitmap read empty at once.
// Depends on psba_pkg, psba_req_if and psba_rsp_if.
module page_slot_bitmap_allocator
  import psba_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  psba_req_if.sink          req_i,
  psba_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned NW   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned EW   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMPW = (EW > CAP_W) ? EW : CAP_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  // Index of the lowest set bit of a word.
  function automatic logic [WORD_LW-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [WORD_LW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_LW'(i);
      end
    end
    return idx;
  endfunction

  logic [1:0]         state_q, state_d;
  logic [CAP_W-1:0]   capacity_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [NW-1:0]      row_vld_q;

  mode_e              mode_q, mode_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [AW-1:0]      chk_w_q, chk_w_d;
  status_e            pend_status_q, pend_status_d;
  logic [SLOT_W-1:0]  pend_slot_q, pend_slot_d;
  status_e            out_status_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_load;

  logic [WORD_W-1:0]  mem [NW];
  logic [WORD_W-1:0]  rdata_q;
  logic               rvld_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data;

  logic               req_fire, cfg_we;
  logic [CMPW-1:0]    cap_x, max_x;
  logic [EW-1:0]      cap_eff, cap_hi, chk_e;
  logic [WORD_LW-1:0] cap_lo;
  logic [WORD_W-1:0]  word, avail, free_bits;
  logic [WORD_LW-1:0] fbit, bsel;
  logic               found, last, obit, in_range;
  logic [AW-1:0]      req_word, slot_word;

  // Configuration port: one capacity register, pready tied high so no transfer is stretched.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == REG_CAPACITY);
  assign prdata = (paddr[APB_AW-1] == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;

  // Effective capacity, clamped to the bitmap size, and its word/bit split.
  assign cap_x   = CMPW'(capacity_q);
  assign max_x   = CMPW'(MAX_SLOTS);
  assign cap_eff = EW'((cap_x > max_x) ? max_x : cap_x);
  assign cap_hi  = cap_eff >> WORD_LW;
  assign cap_lo  = WORD_LW'(cap_eff);

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign in_range    = CMPW'(req_i.slot) < CMPW'(cap_eff);
  assign req_word    = AW'(req_i.slot >> WORD_LW);
  assign slot_word   = AW'(slot_q >> WORD_LW);
  assign bsel        = slot_q[WORD_LW-1:0];

  // A word that was never written reads as all free.
  assign word = rvld_q ? rdata_q : '0;

  // Scan of the word under check: only slots below the capacity count as free.
  assign chk_e = EW'(chk_w_q);
  always_comb begin
    if (chk_e < cap_hi) begin
      avail = '1;
    end else if (chk_e == cap_hi) begin
      avail = (WORD_W'(1) << cap_lo) - WORD_W'(1);
    end else begin
      avail = '0;
    end
  end
  assign free_bits = ~word & avail;
  assign found     = |free_bits;
  assign fbit      = lowest_one(free_bits);
  // The last word to scan is the one holding the top usable slot, partial words included.
  assign last      = ({1'b0, chk_e} + (EW + 1)'(1)) >=
                     ({1'b0, cap_hi} + (EW + 1)'(cap_lo != '0));
  assign obit      = word[bsel];

  // Sequencer: read a bitmap word, modify it and write it back when the operation changes a bit.
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    mode_d        = mode_q;
    slot_d        = slot_q;
    chk_w_d       = chk_w_q;
    pend_status_d = pend_status_q;
    pend_slot_d   = pend_slot_q;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = word;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          mode_d = req_i.mode;
          slot_d = req_i.slot;
          if (req_i.mode == MODE_INSERT) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            chk_w_d = '0;
            state_d = S_SCAN;
          end else if (!in_range) begin
            pend_status_d = ST_RANGE;
            pend_slot_d   = req_i.slot;
            state_d       = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = req_word;
            state_d = S_MOD;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          wr_en         = 1'b1;
          wr_addr       = chk_w_q;
          wr_data       = word | (WORD_W'(1) << fbit);
          cnt_d         = cnt_q + CNT_W'(1);
          pend_status_d = ST_OK;
          pend_slot_d   = SLOT_W'({chk_w_q, fbit});
          state_d       = S_PUT;
        end else if (last) begin
          pend_status_d = ST_FULL;
          pend_slot_d   = '0;
          state_d       = S_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = chk_w_q + AW'(1);
          chk_w_d = chk_w_q + AW'(1);
        end
      end
      S_MOD: begin
        wr_addr       = slot_word;
        pend_slot_d   = slot_q;
        pend_status_d = ST_OK;
        unique case (mode_q)
          MODE_RECOVER: begin
            if (!obit) begin
              wr_en   = 1'b1;
              wr_data = word | (WORD_W'(1) << bsel);
              cnt_d   = cnt_q + CNT_W'(1);
            end
          end
          MODE_DELETE: begin
            if (obit) begin
              wr_en   = 1'b1;
              wr_data = word & ~(WORD_W'(1) << bsel);
              cnt_d   = cnt_q - CNT_W'(1);
            end else begin
              pend_status_d = ST_EMPTY;
            end
          end
          MODE_LOOKUP: begin
            if (!obit) begin
              pend_status_d = ST_EMPTY;
            end
          end
          MODE_INSERT: begin
            pend_status_d = ST_OK;
          end
        endcase
        state_d = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  // Output register keeps a finished item while the next one is accepted.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      capacity_q  <= CAP_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        capacity_q <= pwdata[CAP_W-1:0];
      end
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    slot_q        <= slot_d;
    chk_w_q       <= chk_w_d;
    pend_status_q <= pend_status_d;
    pend_slot_q   <= pend_slot_d;
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_slot_q   <= pend_slot_q;
      out_cnt_q    <= cnt_q;
    end
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      rvld_q  <= row_vld_q[rd_addr];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.result_slot = out_slot_q;
  assign rsp_o.used_count  = out_cnt_q;

endmodule

// ===== rtl/psba_checker.sv =====
// Port-level checks for the page slot bitmap allocator, attached by the bind below.
// Depends on psba_pkg and on the top level page_slot_bitmap_allocator.
module psba_checker
  import psba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic [SLOT_W-1:0] rsp_slot_i,
  input logic [CNT_W-1:0]  rsp_count_i
);

  logic [CNT_W-1:0] last_cnt_q;
  logic             rsp_fire;

  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // Count reported by the previous result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (rsp_fire) begin
      last_cnt_q <= rsp_count_i;
    end
  end

  // A stalled result item holds its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_slot_i) && $stable(rsp_count_i))
    else $error("result item changed while stalled");

  // One item at a time: the block is busy right after it takes an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("input accepted twice in a row");

  // A full page reports slot zero.
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && (rsp_status_i == ST_FULL) |-> rsp_slot_i == '0)
    else $error("page full result carries a nonzero slot");

  // A failed operation leaves the count alone.
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && (rsp_status_i != ST_OK) |-> rsp_count_i == last_cnt_q)
    else $error("failed operation changed the used count");

  // A successful operation moves the count by at most one.
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire && (rsp_status_i == ST_OK) |->
    (rsp_count_i == last_cnt_q) || (rsp_count_i == last_cnt_q + CNT_W'(1)) ||
    (rsp_count_i == last_cnt_q - CNT_W'(1)))
    else $error("used count moved by more than one");

endmodule

bind page_slot_bitmap_allocator psba_checker u_psba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.result_slot),
  .rsp_count_i  (rsp_o.used_count)
);
